@@ sv/hsl2rgb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// shared constants and types for the hsl to rgb conversion pipeline
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

	// default fraction bits of the fixed-point inputs (1.0 = 2**FRAC_BITS)
	localparam int FRAC_BITS_DEF = 16;

	// width of each input field and of each output channel
	localparam int IN_W   = 18;
	localparam int CHAN_W = 8;

	// stream data widths, padded to whole bytes
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 24;

	// segment of the piecewise-linear hue ramp
	typedef enum logic [1:0] {
		RAMP_RISE = 2'd0,
		RAMP_HIGH = 2'd1,
		RAMP_FALL = 2'd2,
		RAMP_LOW  = 2'd3
	} ramp_region_t;

endpackage : hsl2rgb_pkg
`default_nettype wire

@@ sv/hsl2rgb_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsl2rgb_front
// stages 1 to 3: input clamp, lightness times saturation, hue wrap,
// and the shared p, q and q - p terms
// ----------------------------------------------------------------------------
module hsl2rgb_front #(
	parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [hsl2rgb_pkg::IN_W-1:0]  hue,
	input  wire logic [hsl2rgb_pkg::IN_W-1:0]  saturation,
	input  wire logic [hsl2rgb_pkg::IN_W-1:0]  lightness,
	output logic                               valid_s3,
	output logic                               achrom_s3,
	output logic [FRAC_BITS:0]                 l_s3,
	output logic [FRAC_BITS:0]                 p_s3,
	output logic [FRAC_BITS:0]                 q_s3,
	output logic [FRAC_BITS:0]                 d_s3,
	output logic [FRAC_BITS:0]                 tr_s3,
	output logic [FRAC_BITS:0]                 tg_s3,
	output logic [FRAC_BITS:0]                 tb_s3
);

	localparam int VW     = FRAC_BITS + 1;
	localparam int MAG_W  = hsl2rgb_pkg::IN_W - 1;
	localparam int MW     = (VW > MAG_W) ? VW : MAG_W;
	localparam int ONE_I  = 1 << FRAC_BITS;
	localparam int HALF_I = ONE_I / 2;
	localparam int THIRD_I = (ONE_I + 1) / 3;

	localparam logic [MW-1:0] ONE_M   = MW'(ONE_I);
	localparam logic [VW-1:0] ONE_V   = VW'(ONE_I);
	localparam logic [VW-1:0] HALF_V  = VW'(HALF_I);
	localparam logic [VW-1:0] THIRD_V = VW'(THIRD_I);

	// stage 1 registers
	logic          valid_s1;
	logic [VW-1:0] h_s1, s_s1, l_s1;
	// stage 2 registers
	logic          valid_s2;
	logic          achrom_s2;
	logic [VW-1:0] l_s2, s_s2, ls_s2;
	logic [VW-1:0] tr_s2, tg_s2, tb_s2;

	logic [VW-1:0]   h_c, s_c, l_c;
	logic [2*VW-1:0] ls_prod;
	logic [VW:0]     tr_sum;
	logic [VW-1:0]   tr_c, tb_c;
	logic [VW:0]     q_w, p_w, d_w;

	function automatic logic [VW-1:0] clamp_unit(input logic [hsl2rgb_pkg::IN_W-1:0] raw);
		logic [MW-1:0] mag;
		mag = MW'(raw[MAG_W-1:0]);
		if (raw[hsl2rgb_pkg::IN_W-1])
			return '0;
		else if (mag > ONE_M)
			return ONE_V;
		else
			return VW'(mag);
	endfunction

	always_comb begin
		h_c = clamp_unit(hue);
		s_c = clamp_unit(saturation);
		l_c = clamp_unit(lightness);
	end

	// stage 2 logic: one product and the three ramp arguments
	always_comb begin
		ls_prod = (2*VW)'(l_s1) * (2*VW)'(s_s1);
		tr_sum  = {1'b0, h_s1} + {1'b0, THIRD_V};
		if (tr_sum > {1'b0, ONE_V})
			tr_c = VW'(tr_sum - {1'b0, ONE_V});
		else
			tr_c = VW'(tr_sum);
		if (h_s1 < THIRD_V)
			tb_c = h_s1 + ONE_V - THIRD_V;
		else
			tb_c = h_s1 - THIRD_V;
	end

	// stage 3 logic: q, p = 2l - q, and the ramp slope q - p
	always_comb begin
		if (l_s2 < HALF_V)
			q_w = {1'b0, l_s2} + {1'b0, ls_s2};
		else
			q_w = {1'b0, l_s2} + {1'b0, s_s2} - {1'b0, ls_s2};
		p_w = {l_s2, 1'b0} - q_w;
		d_w = {q_w[VW-1:0], 1'b0} - {l_s2, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1      <= h_c;
			s_s1      <= s_c;
			l_s1      <= l_c;

			achrom_s2 <= (s_s1 == '0);
			l_s2      <= l_s1;
			s_s2      <= s_s1;
			ls_s2     <= ls_prod[FRAC_BITS +: VW];
			tr_s2     <= tr_c;
			tg_s2     <= h_s1;
			tb_s2     <= tb_c;

			achrom_s3 <= achrom_s2;
			l_s3      <= l_s2;
			q_s3      <= q_w[VW-1:0];
			p_s3      <= p_w[VW-1:0];
			d_s3      <= d_w[VW-1:0];
			tr_s3     <= tr_s2;
			tg_s3     <= tg_s2;
			tb_s3     <= tb_s2;
		end
	end

endmodule : hsl2rgb_front
`default_nettype wire

@@ sv/hsl2rgb_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsl2rgb_lane
// stages 4 to 7 of one color channel: ramp segment, slope product,
// channel select and scaling to a byte
// ----------------------------------------------------------------------------
module hsl2rgb_lane #(
	parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic                             achrom,
	input  wire logic [FRAC_BITS:0]               l,
	input  wire logic [FRAC_BITS:0]               p,
	input  wire logic [FRAC_BITS:0]               q,
	input  wire logic [FRAC_BITS:0]               d,
	input  wire logic [FRAC_BITS:0]               t,
	output logic [hsl2rgb_pkg::CHAN_W-1:0]        chan_s7
);

	localparam int VW      = FRAC_BITS + 1;
	localparam int CW      = VW + 2;
	localparam int SW      = CW + 8;
	localparam int ONE_I   = 1 << FRAC_BITS;
	localparam int HALF_I  = ONE_I / 2;
	localparam int SIXTH_I = (ONE_I + 3) / 6;
	localparam int TT_I    = (2 * ONE_I + 1) / 3;

	localparam logic [VW-1:0] HALF_V  = VW'(HALF_I);
	localparam logic [VW-1:0] SIXTH_V = VW'(SIXTH_I);
	localparam logic [VW-1:0] TT_V    = VW'(TT_I);
	localparam logic [SW-FRAC_BITS-1:0] CHAN_MAX = (SW-FRAC_BITS)'((1 << hsl2rgb_pkg::CHAN_W) - 1);

	hsl2rgb_pkg::ramp_region_t region_c, region_s4, region_s5;
	logic [VW-1:0]   x_c;
	logic [VW+2:0]   m_w;
	logic [VW-1:0]   m_s4, d_s4, p_s4, q_s4, l_s4;
	logic            achrom_s4, achrom_s5;
	logic [2*VW-1:0] prod_c;
	logic [VW:0]     pr_s5;
	logic [VW-1:0]   p_s5, q_s5, l_s5;
	logic [CW-1:0]   c_c, c_s6;
	logic [SW-1:0]   sc_c;
	logic [SW-FRAC_BITS-1:0] v_c;

	// stage 4: segment and the 6 * distance factor
	always_comb begin
		if (t < SIXTH_V)
			region_c = hsl2rgb_pkg::RAMP_RISE;
		else if (t < HALF_V)
			region_c = hsl2rgb_pkg::RAMP_HIGH;
		else if (t < TT_V)
			region_c = hsl2rgb_pkg::RAMP_FALL;
		else
			region_c = hsl2rgb_pkg::RAMP_LOW;

		unique case (region_c)
			hsl2rgb_pkg::RAMP_RISE: x_c = t;
			hsl2rgb_pkg::RAMP_FALL: x_c = TT_V - t;
			default:                x_c = '0;
		endcase
		m_w = {x_c, 2'b00} + {1'b0, x_c, 1'b0};
	end

	// stage 5: slope product
	always_comb begin
		prod_c = (2*VW)'(d_s4) * (2*VW)'(m_s4);
	end

	// stage 6: channel value
	always_comb begin
		case (region_s5)
			hsl2rgb_pkg::RAMP_HIGH: c_c = CW'(q_s5);
			hsl2rgb_pkg::RAMP_LOW:  c_c = CW'(p_s5);
			default:                c_c = CW'(p_s5) + CW'(pr_s5);
		endcase
		if (achrom_s5)
			c_c = CW'(l_s5);
	end

	// stage 7: times 255, truncate, saturate
	always_comb begin
		sc_c = {c_s6, 8'h00} - SW'(c_s6);
		v_c  = sc_c[SW-1:FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			region_s4 <= region_c;
			m_s4      <= m_w[VW-1:0];
			d_s4      <= d;
			p_s4      <= p;
			q_s4      <= q;
			l_s4      <= l;
			achrom_s4 <= achrom;

			region_s5 <= region_s4;
			pr_s5     <= prod_c[FRAC_BITS +: VW+1];
			p_s5      <= p_s4;
			q_s5      <= q_s4;
			l_s5      <= l_s4;
			achrom_s5 <= achrom_s4;

			c_s6      <= c_c;

			if (v_c > CHAN_MAX)
				chan_s7 <= CHAN_MAX[hsl2rgb_pkg::CHAN_W-1:0];
			else
				chan_s7 <= v_c[hsl2rgb_pkg::CHAN_W-1:0];
		end
	end

endmodule : hsl2rgb_lane
`default_nettype wire

@@ sv/hsl_to_rgb_converter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// converts hue, saturation and lightness in signed fixed point to 8-bit rgb
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (lsb first)                   | tuser/tlast
//  s_*      | in  | hue[17:0] saturation[35:18] lightness[53:36] | none
//  m_*      | out | red[7:0] green[15:8] blue[23:16]              | none
//
//  one transaction in and one out per cycle while the output is not stalled;
//  the pipeline has seven register stages (clamp, product, p/q, segment,
//  slope product, channel select, byte scaling).
//  reset clears only the stage valid bits; the pipeline is empty after it.
//  when the output holds a result and m_tready is low, every stage freezes
//  and s_tready drops; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter #(
	parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// hue[17:0], saturation[35:18], lightness[53:36], zeros above
	input  wire logic [hsl2rgb_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// red[7:0], green[15:8], blue[23:16]
	output logic [hsl2rgb_pkg::OUT_TDATA_W-1:0]       m_tdata
);

	localparam int IW = hsl2rgb_pkg::IN_W;
	localparam int CH = hsl2rgb_pkg::CHAN_W;

	logic adv;
	logic valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic achrom_s3;
	logic [FRAC_BITS:0] l_s3, p_s3, q_s3, d_s3, tr_s3, tg_s3, tb_s3;
	logic [CH-1:0] red_s7, green_s7, blue_s7;

	// whole pipeline moves unless the output transaction is stuck
	assign adv      = !valid_s7 || m_tready;
	assign s_tready = adv;
	assign m_tvalid = valid_s7;
	assign m_tdata  = {blue_s7, green_s7, red_s7};

	hsl2rgb_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.in_valid   (s_tvalid),
		.hue        (s_tdata[IW-1:0]),
		.saturation (s_tdata[2*IW-1:IW]),
		.lightness  (s_tdata[3*IW-1:2*IW]),
		.valid_s3   (valid_s3),
		.achrom_s3  (achrom_s3),
		.l_s3       (l_s3),
		.p_s3       (p_s3),
		.q_s3       (q_s3),
		.d_s3       (d_s3),
		.tr_s3      (tr_s3),
		.tg_s3      (tg_s3),
		.tb_s3      (tb_s3)
	);

	hsl2rgb_lane #(.FRAC_BITS (FRAC_BITS)) u_red (
		.clk (clk), .en (adv), .achrom (achrom_s3), .l (l_s3), .p (p_s3),
		.q (q_s3), .d (d_s3), .t (tr_s3), .chan_s7 (red_s7)
	);

	hsl2rgb_lane #(.FRAC_BITS (FRAC_BITS)) u_green (
		.clk (clk), .en (adv), .achrom (achrom_s3), .l (l_s3), .p (p_s3),
		.q (q_s3), .d (d_s3), .t (tg_s3), .chan_s7 (green_s7)
	);

	hsl2rgb_lane #(.FRAC_BITS (FRAC_BITS)) u_blue (
		.clk (clk), .en (adv), .achrom (achrom_s3), .l (l_s3), .p (p_s3),
		.q (q_s3), .d (d_s3), .t (tb_s3), .chan_s7 (blue_s7)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// a new result only shows up when stage 6 held one and the pipe moved
	a_out_from_s6: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s6 && adv))
		else $error("result appeared without a stage 6 item");

	// a stalled pipeline keeps the valid bits of stages 4 to 6 frozen
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s4) && $stable(valid_s5) && $stable(valid_s6))
		else $error("inner stage moved during stall");

	// a stuck output transaction must push back on the input side
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted while output is stuck");

	// lanes stall together, so a held result keeps all three channels
	a_hold_channels: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(red_s7) && $stable(green_s7) && $stable(blue_s7))
		else $error("channel changed while result held");

endmodule : hsl_to_rgb_converter
`default_nettype wire
